### rtl/brf_pkg.sv
// brf_pkg: shared types and constants of the byte ring FIFO.
// No dependencies; the other rtl files, except brf_ram, refer to it by scoped names.
`default_nettype none

package brf_pkg;

   localparam int CNT_W  = 9;   // size, count, free space, ring pointers
   localparam int DATA_W = 8;
   localparam int ACT_W  = 3;
   localparam int OFS_W  = 8;
   localparam int SUM_W  = 10;  // pointer plus peek offset
   localparam int STEP_W = 4;   // holds SUM_W

   localparam int OQ_DEPTH = 4; // result queue entries
   localparam int OQ_AW    = 2;
   localparam int OQC_W    = 3; // holds OQ_DEPTH

   localparam logic [CNT_W-1:0] SIZE_RESET = 9'd256;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUT   = 3'd0,
      ACT_GET   = 3'd1,
      ACT_CHECK = 3'd2,
      ACT_READ  = 3'd3,
      ACT_PEEK  = 3'd4,
      ACT_FLUSH = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_GET,
      OP_CHECK,
      OP_READ,
      OP_PEEK,
      OP_FLUSH,
      OP_BAD
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_BURST,
      ST_MOD
   } state_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [DATA_W-1:0] data_in;
      logic [CNT_W-1:0]  length;
      logic [OFS_W-1:0]  offset;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] data_out;
      logic              last;
      logic [CNT_W-1:0]  fill_count;
      logic [CNT_W-1:0]  free_space;
   } rsp_type;

   // classified request handed from front to back
   typedef struct packed {
      op_type            op;
      logic [DATA_W-1:0] data;
      logic [CNT_W-1:0]  length;
      logic [OFS_W-1:0]  offset;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/brf_ram.sv
// brf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/brf_mod.sv
// brf_mod: restoring remainder unit, one quotient bit per cycle.
// Depends on brf_pkg for widths.
`default_nettype none

module brf_mod (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [brf_pkg::SUM_W-1:0]   dividend,
   input  wire logic [brf_pkg::CNT_W-1:0]   divisor,
   output logic                             busy,
   output logic      [brf_pkg::CNT_W-1:0]   remainder
);

   logic                        busy_ff, busy_in;
   logic [brf_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [brf_pkg::SUM_W-1:0]   dvd_ff, dvd_in;
   logic [brf_pkg::CNT_W-1:0]   div_ff, div_in;
   logic [brf_pkg::CNT_W-1:0]   rem_ff, rem_in;
   logic [brf_pkg::SUM_W-1:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[brf_pkg::SUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = brf_pkg::STEP_W'(brf_pkg::SUM_W);
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below divisor, so the trial fits SUM_W bits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = brf_pkg::CNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[brf_pkg::CNT_W-1:0];
         end
         dvd_in  = {dvd_ff[brf_pkg::SUM_W-2:0], 1'b0};
         step_in = step_ff - brf_pkg::STEP_W'(1);
         if (step_ff == brf_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/brf_front.sv
// brf_front: takes requests, decodes the action and holds them in a
// two-entry command queue for the sequencer. Depends on brf_pkg.
`default_nettype none

module brf_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire brf_pkg::req_type  req_data,
   input  wire logic              clearing,
   output logic                   cmd_valid,
   output brf_pkg::cmd_type       cmd,
   input  wire logic              cmd_pop
);

   brf_pkg::cmd_type q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       take;
   brf_pkg::cmd_type decoded;

   always_comb begin
      decoded.data   = req_data.data_in;
      decoded.length = req_data.length;
      decoded.offset = req_data.offset;
      unique case (req_data.action)
         brf_pkg::ACT_PUT:   decoded.op = brf_pkg::OP_PUT;
         brf_pkg::ACT_GET:   decoded.op = brf_pkg::OP_GET;
         brf_pkg::ACT_CHECK: decoded.op = brf_pkg::OP_CHECK;
         brf_pkg::ACT_READ:  decoded.op = brf_pkg::OP_READ;
         brf_pkg::ACT_PEEK:  decoded.op = brf_pkg::OP_PEEK;
         brf_pkg::ACT_FLUSH: decoded.op = brf_pkg::OP_FLUSH;
         default:            decoded.op = brf_pkg::OP_BAD;
      endcase
   end

   assign full      = (cnt_ff == 2'd2) || clearing;
   assign take      = push && !full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = take ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(take) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (take) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

### rtl/brf_rspq.sv
// brf_rspq: small result queue in front of the consumer.
// Depends on brf_pkg for the result type and depth.
`default_nettype none

module brf_rspq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire brf_pkg::rsp_type          wr_data,
   input  wire logic                      pop,
   output logic                           empty,
   output brf_pkg::rsp_type               rsp_data,
   output logic [brf_pkg::OQC_W-1:0]      count
);

   brf_pkg::rsp_type q_ff [brf_pkg::OQ_DEPTH];
   logic [brf_pkg::OQ_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [brf_pkg::OQC_W-1:0] cnt_ff, cnt_in;
   logic                      take;

   assign empty    = (cnt_ff == '0);
   assign take     = pop && !empty;
   assign rsp_data = q_ff[rd_ptr_ff];
   assign count    = cnt_ff;
   assign cnt_in   = cnt_ff + brf_pkg::OQC_W'(wr_en) - brf_pkg::OQC_W'(take);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + brf_pkg::OQ_AW'(1);
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + brf_pkg::OQ_AW'(1);
         end
         cnt_ff <= cnt_in;
      end
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

### rtl/brf_back.sv
// brf_back: sequencer that owns the ring state and storage, executes one
// command at a time and stages results. Depends on brf_pkg, brf_ram, brf_mod.
`default_nettype none

module brf_back #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [brf_pkg::CNT_W-1:0]     csr_wdata,
   input  wire logic                          cmd_valid,
   input  wire brf_pkg::cmd_type              cmd,
   output logic                               cmd_pop,
   output logic                               clearing,
   input  wire logic [brf_pkg::OQC_W-1:0]     oq_count,
   output logic                               res_we,
   output brf_pkg::rsp_type                   res_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int BW    = $clog2(MAX_BURST + 1);
   localparam int CW    = brf_pkg::CNT_W;
   localparam logic [PTR_W-1:0] LAST_ADDR = PTR_W'(DEPTH - 1);

   brf_pkg::state_type state_ff, state_in;
   logic [PTR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [CW-1:0]      size_ff, size_in;
   logic [CW-1:0]      rp_ff, rp_in;
   logic [CW-1:0]      wp_ff, wp_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [BW-1:0]      remain_ff, remain_in;
   logic               peek_ok_ff, peek_ok_in;

   logic               pend_valid_ff, pend_valid_in;
   logic               pend_ok_ff, pend_ok_in;
   logic               pend_last_ff, pend_last_in;
   logic               pend_mem_ff, pend_mem_in;
   logic [CW-1:0]      pend_fill_ff, pend_fill_in;
   logic [CW-1:0]      pend_free_ff, pend_free_in;

   logic [CW-1:0]      eff;
   logic [CW-1:0]      rp_inc, wp_inc;
   logic [CW-1:0]      cnt_after;
   logic [CW-1:0]      burst_a, burst_n;
   logic [brf_pkg::SUM_W-1:0] peek_sum;
   logic               can_emit;

   logic                      ram_we;
   logic [PTR_W-1:0]          ram_waddr, ram_raddr;
   logic [brf_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

   logic               mod_start, mod_busy;
   logic [CW-1:0]      mod_rem;

   brf_ram #(
      .WIDTH (brf_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   brf_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (peek_sum),
      .divisor   (eff),
      .busy      (mod_busy),
      .remainder (mod_rem)
   );

   // size 0 acts as 1, oversize acts as DEPTH
   always_comb begin
      if (size_ff == '0) begin
         eff = CW'(1);
      end else if (32'(size_ff) > DEPTH) begin
         eff = CW'(DEPTH);
      end else begin
         eff = size_ff;
      end
   end

   assign rp_inc   = (rp_ff + CW'(1) == eff) ? '0 : rp_ff + CW'(1);
   assign wp_inc   = (wp_ff + CW'(1) == eff) ? '0 : wp_ff + CW'(1);
   assign peek_sum = {1'b0, rp_ff} + brf_pkg::SUM_W'(cmd.offset);
   assign burst_a  = (cmd.length < cnt_ff) ? cmd.length : cnt_ff;
   assign burst_n  = (burst_a < CW'(MAX_BURST)) ? burst_a : CW'(MAX_BURST);
   // credit: queued results plus the one in the staging register
   assign can_emit = ((brf_pkg::OQC_W+1)'(oq_count) + (brf_pkg::OQC_W+1)'(pend_valid_ff))
                     < (brf_pkg::OQC_W+1)'(brf_pkg::OQ_DEPTH);
   assign clearing = (state_ff == brf_pkg::ST_CLEAR);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      size_in       = size_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      remain_in     = remain_ff;
      peek_ok_in    = peek_ok_ff;
      cnt_after     = cnt_ff;
      cmd_pop       = 1'b0;
      mod_start     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = PTR_W'(wp_ff);
      ram_wdata     = cmd.data;
      ram_raddr     = PTR_W'(rp_ff);
      pend_valid_in = 1'b0;
      pend_ok_in    = 1'b0;
      pend_last_in  = 1'b1;
      pend_mem_in   = 1'b0;

      unique case (state_ff)
         brf_pkg::ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = '0;
            clr_addr_in = clr_addr_ff + PTR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = brf_pkg::ST_IDLE;
            end
         end
         brf_pkg::ST_IDLE: begin
            if (cmd_valid && can_emit) begin
               cmd_pop       = 1'b1;
               pend_valid_in = 1'b1;
               unique case (cmd.op)
                  brf_pkg::OP_PUT: begin
                     if (cnt_ff < eff) begin
                        ram_we     = 1'b1;
                        wp_in      = wp_inc;
                        cnt_after  = cnt_ff + CW'(1);
                        pend_ok_in = 1'b1;
                     end
                  end
                  brf_pkg::OP_GET: begin
                     if (cnt_ff != '0) begin
                        rp_in       = rp_inc;
                        cnt_after   = cnt_ff - CW'(1);
                        pend_ok_in  = 1'b1;
                        pend_mem_in = 1'b1;
                     end
                  end
                  brf_pkg::OP_CHECK: begin
                     pend_ok_in = (cmd.length <= eff - cnt_ff);
                  end
                  brf_pkg::OP_READ: begin
                     if (burst_n != '0) begin
                        rp_in        = rp_inc;
                        cnt_after    = cnt_ff - CW'(1);
                        pend_ok_in   = 1'b1;
                        pend_mem_in  = 1'b1;
                        pend_last_in = (burst_n == CW'(1));
                        remain_in    = BW'(burst_n - CW'(1));
                        if (burst_n != CW'(1)) begin
                           state_in = brf_pkg::ST_BURST;
                        end
                     end
                  end
                  brf_pkg::OP_PEEK: begin
                     if (peek_sum < {1'b0, eff}) begin
                        ram_raddr   = PTR_W'(peek_sum);
                        pend_ok_in  = (CW'(cmd.offset) < cnt_ff);
                        pend_mem_in = 1'b1;
                     end else begin
                        // wraps past the ring end (more than once in small rings): take a remainder
                        pend_valid_in = 1'b0;
                        mod_start     = 1'b1;
                        peek_ok_in    = (CW'(cmd.offset) < cnt_ff);
                        state_in      = brf_pkg::ST_MOD;
                     end
                  end
                  brf_pkg::OP_FLUSH: begin
                     cnt_after  = '0;
                     rp_in      = wp_ff;
                     pend_ok_in = 1'b1;
                  end
                  default: begin
                     pend_ok_in = 1'b0;
                  end
               endcase
            end
         end
         brf_pkg::ST_BURST: begin
            if (can_emit) begin
               pend_valid_in = 1'b1;
               rp_in         = rp_inc;
               cnt_after     = cnt_ff - CW'(1);
               pend_ok_in    = 1'b1;
               pend_mem_in   = 1'b1;
               pend_last_in  = (remain_ff == BW'(1));
               remain_in     = remain_ff - BW'(1);
               if (remain_ff == BW'(1)) begin
                  state_in = brf_pkg::ST_IDLE;
               end
            end
         end
         brf_pkg::ST_MOD: begin
            if (!mod_busy && can_emit) begin
               pend_valid_in = 1'b1;
               ram_raddr     = PTR_W'(mod_rem);
               pend_ok_in    = peek_ok_ff;
               pend_mem_in   = 1'b1;
               state_in      = brf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brf_pkg::ST_IDLE;
         end
      endcase

      cnt_in       = cnt_after;
      pend_fill_in = cnt_after;
      pend_free_in = eff - cnt_after;

      // size write also empties the ring; storage is kept
      if (csr_we) begin
         size_in = csr_wdata;
         rp_in   = '0;
         wp_in   = '0;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= brf_pkg::ST_CLEAR;
         clr_addr_ff   <= '0;
         size_ff       <= brf_pkg::SIZE_RESET;
         rp_ff         <= '0;
         wp_ff         <= '0;
         cnt_ff        <= '0;
         remain_ff     <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         size_ff       <= size_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         cnt_ff        <= cnt_in;
         remain_ff     <= remain_in;
         pend_valid_ff <= pend_valid_in;
      end
      peek_ok_ff   <= peek_ok_in;
      pend_ok_ff   <= pend_ok_in;
      pend_last_ff <= pend_last_in;
      pend_mem_ff  <= pend_mem_in;
      pend_fill_ff <= pend_fill_in;
      pend_free_ff <= pend_free_in;
   end

   // RAM data lands in the cycle after the read is issued
   assign res_we              = pend_valid_ff;
   assign res_data.ok         = pend_ok_ff;
   assign res_data.data_out   = pend_mem_ff ? ram_rdata : '0;
   assign res_data.last       = pend_last_ff;
   assign res_data.fill_count = pend_fill_ff;
   assign res_data.free_space = pend_free_ff;

   a_cnt_in_ring: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= eff)
      else $error("fill count above ring size");

   a_ptr_in_ring: assert property (@(posedge clock) disable iff (reset)
      (rp_ff < eff) && (wp_ff < eff))
      else $error("ring pointer outside ring");

   a_no_cmd_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brf_pkg::ST_CLEAR) |-> !cmd_pop)
      else $error("command taken during clearing pass");

   a_rspq_room: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (oq_count < brf_pkg::OQC_W'(brf_pkg::OQ_DEPTH)))
      else $error("staged result with no room in result queue");

endmodule

`default_nettype wire

### rtl/byte_ring_fifo.sv
// byte_ring_fifo: top level of the byte ring FIFO.
// Depends on brf_pkg, brf_front, brf_back (with brf_ram, brf_mod), brf_rspq.
//
// Byte ring FIFO with a run-time ring size (csr_wdata, 0 acts as 1, values
// above DEPTH act as DEPTH; writing it also empties the ring). Requests
// enter through a queue port (push/full) and results leave through one
// (pop/empty); every request gives one result, a block read gives one
// result per byte popped with last set on the final one. After reset the
// block runs a clearing pass over the storage, with full high; size
// writes are taken during it. A front stage decodes requests into a
// two-entry command queue, a sequencer executes them against the ring
// storage (a RAM with registered read), and results pass a staging register
// into a four-entry result queue. The sequencer completes put, get, block
// check, flush and a peek that does not wrap without leaving its idle state,
// and a block read streams one byte per cycle while the result queue has
// room, so with pop held high and no wrapping peek the block sustains one
// result per cycle. A peek that wraps past the ring end holds the sequencer
// in the bit-serial remainder unit until its remainder is ready. A result
// passes the command queue, staging register and result queue to the ports.
`default_nettype none

module byte_ring_fifo #(
   parameter int DEPTH     = 256,
   parameter int MAX_BURST = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request side
   input  wire logic                      push,
   output logic                           full,
   input  wire brf_pkg::req_type          req_data,
   // result side
   output logic                           empty,
   input  wire logic                      pop,
   output brf_pkg::rsp_type               rsp_data,
   // ring size register
   input  wire logic                      csr_we,
   input  wire logic [brf_pkg::CNT_W-1:0] csr_wdata
);

   logic                      cmd_valid;
   logic                      cmd_pop;
   brf_pkg::cmd_type          cmd;
   logic                      clearing;
   logic [brf_pkg::OQC_W-1:0] oq_count;
   logic                      res_we;
   brf_pkg::rsp_type          res_data;

   // front: decode and command queue
   brf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .clearing  (clearing),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // back: ring state, storage and sequencing
   brf_back #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .oq_count  (oq_count),
      .res_we    (res_we),
      .res_data  (res_data)
   );

   // result queue toward the consumer
   brf_rspq u_rspq (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (res_we),
      .wr_data  (res_data),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data),
      .count    (oq_count)
   );

endmodule

`default_nettype wire
